// ===== hdl/fbpa_pkg.sv =====
`timescale 1ns / 1ps

package fbpa_pkg;

    localparam int MAX_BLOCKS = 256;
    localparam int IDX_W      = $clog2(MAX_BLOCKS);
    localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
    localparam int ADDR_W     = 32;
    localparam int SIZE_W     = 16;
    localparam int PROD_W     = IDX_W + SIZE_W;
    localparam int APB_DW     = 32;
    localparam int APB_AW     = 4;
    localparam int STATUS_W   = 2;

    localparam logic [ADDR_W-1:0] BASE_RESET  = '0;
    localparam logic [SIZE_W-1:0] SIZE_RESET  = SIZE_W'(4);
    localparam logic [CNT_W-1:0]  COUNT_RESET = CNT_W'(MAX_BLOCKS);

    typedef enum logic [1:0] {
        REG_BASE  = 2'd0,
        REG_SIZE  = 2'd1,
        REG_COUNT = 2'd2,
        REG_NONE  = 2'd3
    } t_reg_idx;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK     = 2'd0,
        STAT_NOFREE = 2'd1,
        STAT_FULL   = 2'd2
    } t_status;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_op;

    typedef enum logic {
        S_IDLE   = 1'b0,
        S_FINISH = 1'b1
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start;
        logic finish;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_busy;
    } t_stat;

    // Saturate the configured count at the pool capacity.
    function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] cnt);
        logic [CNT_W-1:0] cap;
        cap = CNT_W'(MAX_BLOCKS);
        return (cnt > cap) ? cap : cnt;
    endfunction

endpackage

// ===== hdl/fbpa_req_if.sv =====
`timescale 1ns / 1ps

interface fbpa_req_if;
    import fbpa_pkg::*;

    logic              valid;
    logic              ready;
    logic              op;
    logic [IDX_W-1:0]  block_index;

    modport source (output valid, output op, output block_index, input ready);
    modport sink   (input valid, input op, input block_index, output ready);
endinterface

// ===== hdl/fbpa_rsp_if.sv =====
`timescale 1ns / 1ps

interface fbpa_rsp_if;
    import fbpa_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [STATUS_W-1:0]  status;
    logic [IDX_W-1:0]     granted_index;
    logic [ADDR_W-1:0]    granted_address;
    logic [CNT_W-1:0]     blocks_free;

    modport source (output valid, output status, output granted_index,
                    output granted_address, output blocks_free, input ready);
    modport sink   (input valid, input status, input granted_index,
                    input granted_address, input blocks_free, output ready);
endinterface

// ===== hdl/fbpa_ctrl.sv =====
`timescale 1ns / 1ps

module fbpa_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  fbpa_pkg::t_stat i_stat,
    output fbpa_pkg::t_cmd  o_cmd
);
    import fbpa_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_in_ready   = 1'b0;
        o_cmd.start  = 1'b0;
        o_cmd.finish = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                // No word is taken while reset is held.
                o_in_ready = i_rst_n;
                if (i_in_valid && i_rst_n) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_FINISH;
                end
            end
            S_FINISH: begin
                // Commit only once the output register can take the word.
                if (!i_stat.out_busy) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

// ===== hdl/fbpa_dp.sv =====
`timescale 1ns / 1ps

module fbpa_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  fbpa_pkg::t_cmd                  i_cmd,
    output fbpa_pkg::t_stat                 o_stat,
    input  logic                            i_op,
    input  logic [fbpa_pkg::IDX_W-1:0]      i_block_index,
    input  logic                            i_cfg_we,
    input  logic [fbpa_pkg::APB_AW-1:0]     i_cfg_addr,
    input  logic [fbpa_pkg::APB_DW-1:0]     i_cfg_wdata,
    output logic [fbpa_pkg::APB_DW-1:0]     o_cfg_rdata,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [fbpa_pkg::STATUS_W-1:0]   o_status,
    output logic [fbpa_pkg::IDX_W-1:0]      o_granted_index,
    output logic [fbpa_pkg::ADDR_W-1:0]     o_granted_address,
    output logic [fbpa_pkg::CNT_W-1:0]      o_blocks_free
);
    import fbpa_pkg::*;

    // Configuration registers.
    logic [ADDR_W-1:0]     r_base;
    logic [SIZE_W-1:0]     r_size;
    logic [CNT_W-1:0]      r_count;

    // Free list state.
    logic [IDX_W-1:0]      r_head;
    logic [CNT_W-1:0]      r_free;
    logic [IDX_W-1:0]      r_link [MAX_BLOCKS];
    logic [MAX_BLOCKS-1:0] r_valid;

    // Item captured at acceptance.
    logic                  r_op;
    logic [IDX_W-1:0]      r_idx;
    logic [IDX_W-1:0]      r_rd_data;
    logic                  r_rd_vld;
    logic [PROD_W-1:0]     r_prod;

    // Output register.
    logic                  r_out_valid;
    logic [STATUS_W-1:0]   r_status;
    logic [IDX_W-1:0]      r_gidx;
    logic [ADDR_W-1:0]     r_gaddr;
    logic [CNT_W-1:0]      r_bfree;

    t_reg_idx              cfg_idx;
    logic                  cfg_hit;
    logic [CNT_W-1:0]      new_count;
    logic [CNT_W-1:0]      eff;
    logic [IDX_W-1:0]      link_next;
    logic                  can_alloc;
    logic                  can_free;
    logic                  link_we;

    assign cfg_idx   = t_reg_idx'(i_cfg_addr[3:2]);
    assign cfg_hit   = i_cfg_we && (cfg_idx != REG_NONE);
    assign new_count = (i_cfg_we && cfg_idx == REG_COUNT) ? i_cfg_wdata[CNT_W-1:0] : r_count;
    assign eff       = eff_count(r_count);

    // An entry never written since the last rebuild holds its index plus one.
    assign link_next = r_rd_vld ? r_rd_data : r_head + IDX_W'(1);
    assign can_alloc = (r_free != '0);
    assign can_free  = (r_free < eff);
    assign link_we   = i_cmd.finish && (r_op == OP_FREE) && can_free;

    assign o_stat.out_busy = r_out_valid && !i_out_ready;

    always_comb begin
        unique case (cfg_idx)
            REG_BASE:  o_cfg_rdata = APB_DW'(r_base);
            REG_SIZE:  o_cfg_rdata = APB_DW'(r_size);
            REG_COUNT: o_cfg_rdata = APB_DW'(r_count);
            default:   o_cfg_rdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base  <= BASE_RESET;
            r_size  <= SIZE_RESET;
            r_count <= COUNT_RESET;
            r_head  <= '0;
            r_free  <= eff_count(COUNT_RESET);
            r_valid <= '0;
        end else if (cfg_hit) begin
            unique case (cfg_idx)
                REG_BASE:  r_base  <= i_cfg_wdata[ADDR_W-1:0];
                REG_SIZE:  r_size  <= i_cfg_wdata[SIZE_W-1:0];
                REG_COUNT: r_count <= i_cfg_wdata[CNT_W-1:0];
                default:   r_base  <= r_base;
            endcase
            r_head  <= '0;
            r_free  <= eff_count(new_count);
            r_valid <= '0;
        end else if (i_cmd.finish) begin
            if (r_op == OP_ALLOC) begin
                if (can_alloc) begin
                    r_head <= link_next;
                    r_free <= r_free - CNT_W'(1);
                end
            end else if (can_free) begin
                r_head         <= r_idx;
                r_free         <= r_free + CNT_W'(1);
                r_valid[r_idx] <= 1'b1;
            end
        end
    end

    // Link memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (link_we) begin
            r_link[r_idx] <= r_head;
        end
        if (i_cmd.start) begin
            r_rd_data <= r_link[r_head];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_op     <= i_op;
            r_idx    <= i_block_index;
            r_rd_vld <= r_valid[r_head];
            r_prod   <= PROD_W'(r_head) * PROD_W'(r_size);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_gidx  <= '0;
            r_gaddr <= '0;
            if (r_op == OP_ALLOC) begin
                if (can_alloc) begin
                    r_status <= STAT_OK;
                    r_gidx   <= r_head;
                    r_gaddr  <= r_base + ADDR_W'(r_prod);
                    r_bfree  <= r_free - CNT_W'(1);
                end else begin
                    r_status <= STAT_NOFREE;
                    r_bfree  <= r_free;
                end
            end else begin
                if (can_free) begin
                    r_status <= STAT_OK;
                    r_bfree  <= r_free + CNT_W'(1);
                end else begin
                    r_status <= STAT_FULL;
                    r_bfree  <= r_free;
                end
            end
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_status          = r_status;
    assign o_granted_index   = r_gidx;
    assign o_granted_address = r_gaddr;
    assign o_blocks_free     = r_bfree;

endmodule

// ===== hdl/fixed_block_pool_allocator.sv =====
`timescale 1ns / 1ps
// A result word is registered in the finish state that follows acceptance of its request,
// later only while the output register still holds an unaccepted word.
// A new request is not taken until the current one is finished, since the registered read of the
// link memory must complete before the list head can be updated.
// Reset (synchronous, active low) restores the register defaults and rebuilds
// the free chain at once by clearing the per-entry valid bits; no clearing pass.
module fixed_block_pool_allocator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    fbpa_req_if.sink                      i_req,
    fbpa_rsp_if.source                    o_rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [fbpa_pkg::APB_AW-1:0]   paddr,
    input  logic [fbpa_pkg::APB_DW-1:0]   pwdata,
    output logic [fbpa_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);
    import fbpa_pkg::*;

    t_cmd  cmd;
    t_stat stat;
    logic  in_ready;
    logic  cfg_we;

    assign pready      = 1'b1;
    assign cfg_we      = psel && penable && pwrite;
    assign i_req.ready = in_ready;

    fbpa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    fbpa_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .i_op              (i_req.op),
        .i_block_index     (i_req.block_index),
        .i_cfg_we          (cfg_we),
        .i_cfg_addr        (paddr),
        .i_cfg_wdata       (pwdata),
        .o_cfg_rdata       (prdata),
        .o_out_valid       (o_rsp.valid),
        .i_out_ready       (o_rsp.ready),
        .o_status          (o_rsp.status),
        .o_granted_index   (o_rsp.granted_index),
        .o_granted_address (o_rsp.granted_address),
        .o_blocks_free     (o_rsp.blocks_free)
    );

endmodule
